### rtl/core/rgst_pkg.sv
package rgst_pkg;

  // Selector codes carried in s_tuser.
  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_STEP    = 1'b1;

  localparam int RAND_W    = 31;
  localparam int COORD_O_W = 4;
  localparam int PEND_W    = 11;
  localparam int DIV_STEPS = RAND_W;

  // Neighbor visiting order.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

endpackage

### rtl/core/random_grid_spanning_tree_core.sv
// Grows a random maze on a GRID_W x GRID_H grid by randomized Prim's algorithm. Each input
// item (s_tuser = 1) carries a random number that picks one frontier edge by modulo of the
// edge count; the item with s_tuser = 0 restarts the maze. Every item gives exactly one
// result item. The visited map and the ordered frontier list live in two synchronous
// memories. After reset and after each restart a clearing pass runs over every cell of the
// visited map while no item is accepted. With the result register free, a step runs the
// bit-serial modulo, then moves each frontier entry after the picked one down to close the
// gap, one frontier memory access per cycle, and when it opens a wall it then checks each
// neighbor inside the grid. The block may take the next item while a result still waits.
module random_grid_spanning_tree_core #(
  parameter int GRID_W         = 16,
  parameter int GRID_H         = 16,
  parameter int FRONTIER_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // random_value[30:0], zero fill
  input  logic [0:0]  s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  // opened[0], from_x[4:1], from_y[8:5], to_x[12:9], to_y[16:13], done_res[17],
  // pending[28:18], zero fill
  output logic [31:0] m_tdata
);
  import rgst_pkg::*;

  localparam int CW    = $clog2((GRID_W > GRID_H) ? GRID_W : GRID_H);
  localparam int NCELL = GRID_W * GRID_H;
  localparam int VAW   = $clog2(NCELL);
  localparam int FAW   = $clog2(FRONTIER_DEPTH);
  localparam int CNTW  = $clog2(FRONTIER_DEPTH + 1);

  typedef struct packed {
    logic [CW-1:0] fx;
    logic [CW-1:0] fy;
    logic [CW-1:0] tx;
    logic [CW-1:0] ty;
  } edge_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_PICK, S_GRAB, S_SHIFT,
    S_VREAD, S_VCHK, S_NEIGH, S_NCHK, S_RESULT
  } state_t;

  function automatic logic [VAW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    cell_addr = VAW'(VAW'(y) * VAW'(GRID_W) + VAW'(x));
  endfunction

  state_t          state;
  logic [VAW-1:0]  clr_addr;
  logic            clr_restart;
  logic [CNTW-1:0] count;
  logic [RAND_W-1:0] dvd;
  logic [CNTW-1:0] rem;
  logic [4:0]      div_cnt;
  logic [FAW-1:0]  pos;
  logic [CNTW-1:0] ptr;
  logic            sh_vld;
  logic [FAW-1:0]  sh_addr;
  edge_t           cur;
  logic [1:0]      nb_idx;
  logic            res_opened;
  logic            res_edge;

  // Memories
  logic [0:0]     vis_mem [NCELL];
  edge_t          fr_mem  [FRONTIER_DEPTH];
  logic           vis_we, vis_wdata, vis_rdata;
  logic [VAW-1:0] vis_waddr, vis_raddr;
  logic           fr_we;
  logic [FAW-1:0] fr_waddr, fr_raddr;
  edge_t          fr_wdata, fr_rdata;

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata <= vis_mem[vis_raddr][0];
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      fr_mem[fr_waddr] <= fr_wdata;
    end
    fr_rdata <= fr_mem[fr_raddr];
  end

  // Neighbor of the current target cell.
  logic [CW-1:0]  nx, ny;
  logic           n_in;
  logic [VAW-1:0] taddr, naddr;

  always_comb begin
    nx   = cur.tx;
    ny   = cur.ty;
    n_in = 1'b0;
    unique case (nb_idx)
      DIR_UP: begin
        ny   = cur.ty - CW'(1);
        n_in = (cur.ty != '0);
      end
      DIR_DOWN: begin
        ny   = cur.ty + CW'(1);
        n_in = ((CW + 1)'(cur.ty) + (CW + 1)'(1)) < (CW + 1)'(GRID_H);
      end
      DIR_RIGHT: begin
        nx   = cur.tx + CW'(1);
        n_in = ((CW + 1)'(cur.tx) + (CW + 1)'(1)) < (CW + 1)'(GRID_W);
      end
      DIR_LEFT: begin
        nx   = cur.tx - CW'(1);
        n_in = (cur.tx != '0);
      end
      default: ;
    endcase
  end

  assign taddr = cell_addr(cur.tx, cur.ty);
  assign naddr = cell_addr(nx, ny);

  logic room;
  assign room = count < CNTW'(FRONTIER_DEPTH);

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_addr;
    vis_wdata = (clr_addr == '0);
    vis_raddr = (state == S_VREAD) ? taddr : naddr;
    if (state == S_CLEAR) begin
      vis_we = 1'b1;
    end else if (state == S_VCHK && !vis_rdata) begin
      vis_we    = 1'b1;
      vis_waddr = taddr;
      vis_wdata = 1'b1;
    end
  end

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = '0;
    fr_wdata = '{fx: '0, fy: '0, tx: '0, ty: CW'(1)};
    fr_raddr = (state == S_SHIFT) ? ptr[FAW-1:0] : pos;
    if (state == S_CLEAR) begin
      fr_we = 1'b1;
    end else if (state == S_SHIFT && sh_vld) begin
      fr_we    = 1'b1;
      fr_waddr = sh_addr - FAW'(1);
      fr_wdata = fr_rdata;
    end else if (state == S_NCHK && !vis_rdata && room) begin
      fr_we    = 1'b1;
      fr_waddr = count[FAW-1:0];
      fr_wdata = '{fx: cur.tx, fy: cur.ty, tx: nx, ty: ny};
    end
  end

  logic [CNTW:0] rem_sh;
  assign rem_sh = {rem, dvd[RAND_W-1]};

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_restart <= 1'b0;
      m_tvalid    <= 1'b0;
      count       <= CNTW'(1);
      div_cnt     <= '0;
      nb_idx      <= '0;
      sh_vld      <= 1'b0;
    end else begin
      // A new result in S_RESULT takes the register over by itself.
      if (m_tvalid && m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          count <= CNTW'(1);
          if (clr_addr == VAW'(NCELL - 1)) begin
            clr_addr   <= '0;
            res_opened <= 1'b0;
            res_edge   <= 1'b0;
            state      <= clr_restart ? S_RESULT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + VAW'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            dvd     <= s_tdata[RAND_W-1:0];
            rem     <= '0;
            div_cnt <= '0;
            if (s_tuser[0] == FUNC_RESTART) begin
              clr_restart <= 1'b1;
              state       <= S_CLEAR;
            end else if (count == '0) begin
              res_opened <= 1'b0;
              res_edge   <= 1'b0;
              state      <= S_RESULT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // One quotient bit per cycle; only the remainder is kept.
          if (rem_sh >= {1'b0, count}) begin
            rem <= CNTW'(rem_sh - {1'b0, count});
          end else begin
            rem <= rem_sh[CNTW-1:0];
          end
          dvd     <= dvd << 1;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(DIV_STEPS - 1)) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          pos   <= rem[FAW-1:0];
          state <= S_GRAB;
        end
        S_GRAB: begin
          // The read of the picked entry is issued from pos in this cycle.
          state  <= S_SHIFT;
          ptr    <= CNTW'(pos) + CNTW'(1);
          sh_vld <= 1'b0;
        end
        S_SHIFT: begin
          if (!sh_vld && ptr == CNTW'(pos) + CNTW'(1)) begin
            cur <= fr_rdata;
          end
          if (ptr < count) begin
            sh_vld  <= 1'b1;
            sh_addr <= ptr[FAW-1:0];
            ptr     <= ptr + CNTW'(1);
          end else begin
            sh_vld <= 1'b0;
            if (!sh_vld) begin
              count <= count - CNTW'(1);
              state <= S_VREAD;
            end
          end
        end
        S_VREAD: begin
          state <= S_VCHK;
        end
        S_VCHK: begin
          res_edge <= 1'b1;
          nb_idx   <= '0;
          if (vis_rdata) begin
            res_opened <= 1'b0;
            state      <= S_RESULT;
          end else begin
            res_opened <= 1'b1;
            state      <= S_NEIGH;
          end
        end
        S_NEIGH: begin
          if (n_in) begin
            state <= S_NCHK;
          end else if (nb_idx == DIR_LEFT) begin
            state <= S_RESULT;
          end else begin
            nb_idx <= nb_idx + 2'd1;
          end
        end
        S_NCHK: begin
          if (!vis_rdata && room) begin
            count <= count + CNTW'(1);
          end
          if (nb_idx == DIR_LEFT) begin
            state <= S_RESULT;
          end else begin
            nb_idx <= nb_idx + 2'd1;
            state  <= S_NEIGH;
          end
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            m_tdata     <= {3'b000,
                            PEND_W'(count),
                            (count == '0),
                            res_edge ? COORD_O_W'(cur.ty) : COORD_O_W'(0),
                            res_edge ? COORD_O_W'(cur.tx) : COORD_O_W'(0),
                            res_edge ? COORD_O_W'(cur.fy) : COORD_O_W'(0),
                            res_edge ? COORD_O_W'(cur.fx) : COORD_O_W'(0),
                            res_opened};
            clr_restart <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import rgst_pkg::*;

  typedef struct packed {
    logic [3:0] fx;
    logic [3:0] fy;
    logic [3:0] tx;
    logic [3:0] ty;
  } wall_t;

  // Fields from the highest bit down, so that opened lands in bit 0.
  typedef struct packed {
    logic [10:0] pending;
    logic        done_res;
    logic [3:0]  ty;
    logic [3:0]  tx;
    logic [3:0]  fy;
    logic [3:0]  fx;
    logic        opened;
  } maze_res_t;

  typedef struct {
    logic        func;
    logic [30:0] rnd;
    bit          typed;
    maze_res_t   res;
  } stim_row_t;

  localparam int GW = 16;
  localparam int GH = 16;
  localparam int FDEPTH = 1024;
  localparam int RANDOM_ITEMS = 1030;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = FUNC_RESTART;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;

  random_grid_spanning_tree_core dut (.*);

  always #5 clk = ~clk;

  // Software copy of the maze state.
  bit [GW*GH-1:0] seen_cells;
  wall_t          walls [$];

  maze_res_t expected_walls [$];
  int        errors = 0;
  int        sent = 0;
  int        opened_cnt = 0;
  int        empty_cnt = 0;
  int        restart_cnt = 0;
  bit        hold_rx = 0;
  bit        burst = 0;

  function automatic void wall_append(wall_t w);
    walls.insert(walls.size(), w);
  endfunction

  function automatic void maze_restart();
    seen_cells = '0;
    seen_cells[0] = 1'b1;
    walls = {};
    wall_append('{fx: 4'd0, fy: 4'd0, tx: 4'd0, ty: 4'd1});
  endfunction

  function automatic maze_res_t maze_pick(logic func, logic [30:0] rnd);
    maze_res_t r;
    wall_t     w;
    int        pos, nx, ny;
    int        dx [4] = '{0, 0, 1, -1};
    int        dy [4] = '{-1, 1, 0, 0};
    r = '0;
    if (func == FUNC_RESTART) begin
      maze_restart();
      restart_cnt++;
    end else if (walls.size() != 0) begin
      pos = int'(32'(rnd) % walls.size());
      w = walls[pos];
      walls.delete(pos);
      r.fx = w.fx;
      r.fy = w.fy;
      r.tx = w.tx;
      r.ty = w.ty;
      if (!seen_cells[w.ty * GW + w.tx]) begin
        seen_cells[w.ty * GW + w.tx] = 1'b1;
        r.opened = 1'b1;
        opened_cnt++;
        for (int d = 0; d < 4; d++) begin
          nx = int'(w.tx) + dx[d];
          ny = int'(w.ty) + dy[d];
          if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
          if (seen_cells[ny * GW + nx]) continue;
          if (walls.size() >= FDEPTH) continue;
          wall_append('{fx: w.tx, fy: w.ty, tx: 4'(nx), ty: 4'(ny)});
        end
      end
    end else begin
      empty_cnt++;
    end
    r.pending = 11'(walls.size());
    r.done_res = (walls.size() == 0);
    return r;
  endfunction

  function automatic logic [30:0] pick_rnd();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 15));
      1: return 31'h7FFF_FFFF;
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_item(logic func, logic [30:0] rnd, bit typed, maze_res_t typed_res);
    int gap;
    maze_res_t r;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, rnd};
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    r = maze_pick(func, rnd);
    expected_walls.insert(expected_walls.size(), typed ? typed_res : r);
    sent++;
    if (sent % 40 == 0) burst = ($urandom_range(0, 2) == 0);
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin : result_side
    int stall;
    maze_res_t got, want;
    @(negedge rst);
    forever begin
      stall = hold_rx ? 400 : (burst ? 0 : $urandom_range(0, 9));
      hold_rx = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata[28:0];
      if (expected_walls.size() == 0) begin
        $error("result item with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want = expected_walls.pop_front();
        if (got.opened !== want.opened) begin
          $error("opened: expected %0d, got %0d", want.opened, got.opened); errors++;
        end
        if (got.fx !== want.fx) begin
          $error("from_x: expected %0d, got %0d", want.fx, got.fx); errors++;
        end
        if (got.fy !== want.fy) begin
          $error("from_y: expected %0d, got %0d", want.fy, got.fy); errors++;
        end
        if (got.tx !== want.tx) begin
          $error("to_x: expected %0d, got %0d", want.tx, got.tx); errors++;
        end
        if (got.ty !== want.ty) begin
          $error("to_y: expected %0d, got %0d", want.ty, got.ty); errors++;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, got.done_res); errors++;
        end
        if (got.pending !== want.pending) begin
          $error("pending: expected %0d, got %0d", want.pending, got.pending); errors++;
        end
      end
    end
  end

  initial begin : limit
    #80ms;
    $display("[random_grid_spanning_tree_core] ERROR");
    $finish;
  end

  initial begin : main
    stim_row_t dir_rows [$];
    maze_res_t restart_res;
    maze_res_t none;
    int extra_empty;
    restart_res = '0;
    restart_res.pending = 11'd1;
    none = '0;
    dir_rows = '{
      '{FUNC_STEP,    31'd0,           0, none},
      '{FUNC_STEP,    31'h7FFF_FFFF,   0, none},
      '{FUNC_STEP,    31'h5555_5555,   0, none},
      '{FUNC_STEP,    31'h2AAA_AAAA,   0, none},
      '{FUNC_STEP,    31'd1,           0, none},
      '{FUNC_RESTART, 31'h7FFF_FFFF,   1, restart_res},
      '{FUNC_RESTART, 31'd0,           1, restart_res},
      '{FUNC_STEP,    31'h4000_0000,   0, none},
      '{FUNC_STEP,    31'd3,           0, none},
      '{FUNC_STEP,    31'd2,           0, none},
      '{FUNC_STEP,    31'h7FFF_FFFE,   0, none},
      '{FUNC_STEP,    31'h0000_FFFF,   0, none},
      '{FUNC_STEP,    31'h7FFF_0000,   0, none},
      '{FUNC_STEP,    31'd7,           0, none},
      '{FUNC_RESTART, 31'h1234_5678,   1, restart_res},
      '{FUNC_STEP,    31'd0,           0, none},
      '{FUNC_STEP,    31'd0,           0, none},
      '{FUNC_STEP,    31'd0,           0, none}
    };
    maze_restart();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_item(dir_rows[i].func, dir_rows[i].rnd, dir_rows[i].typed, dir_rows[i].res);

    // Let the block drain completely before the random part.
    s_tvalid <= 1'b0;
    wait (expected_walls.size() == 0);
    @(posedge clk);
    hold_rx = 1;
    send_item(FUNC_RESTART, pick_rnd(), 0, none);

    // Grow one maze to completion, then poke the empty frontier a few times.
    extra_empty = 0;
    while (extra_empty < 4) begin
      if (walls.size() == 0) extra_empty++;
      send_item(FUNC_STEP, pick_rnd(), 0, none);
    end
    send_item(FUNC_RESTART, pick_rnd(), 0, none);

    // Mostly steps with the occasional restart.
    while (sent < RANDOM_ITEMS)
      send_item(($urandom_range(0, 149) == 0) ? FUNC_RESTART : FUNC_STEP, pick_rnd(), 0, none);
    s_tvalid <= 1'b0;

    wait (expected_walls.size() == 0);
    repeat (1200) @(posedge clk);
    $display("Sent %0d items: %0d restarts, %0d walls opened, %0d steps on an empty frontier.",
             sent, restart_cnt, opened_cnt, empty_cnt);
    if (errors == 0 && expected_walls.size() == 0)
      $display("[random_grid_spanning_tree_core] OK");
    else
      $display("[random_grid_spanning_tree_core] ERROR");
    $finish;
  end

endmodule
